// File: design/lud_pkg.sv
// lud_pkg: shared constants, types and helper functions for the lu factorization block
// no dependencies; compiled first

package lud_pkg;

    localparam int MAX_ORDER  = 8;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int IDX_W      = $clog2(MAX_ORDER);
    localparam int ADDR_W     = 2 * IDX_W;
    localparam int SIZE_W     = IDX_W + 1;
    localparam int CNT_W      = ADDR_W + 1;
    localparam int EPS_W      = 17;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int DIFF_W     = DATA_WIDTH + FRAC_BITS + 1;

    localparam logic signed [DATA_WIDTH-1:0] Q_ONE   = DATA_WIDTH'(1 << FRAC_BITS);
    localparam logic signed [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [0:0] CFG_MATRIX_SIZE  = 1'd0;
    localparam logic [0:0] CFG_PIVOT_EPSILON = 1'd1;

    typedef enum logic [4:0] {
        S_LOAD, S_INIT, S_COL, S_SRCH_RD, S_SRCH_CMP, S_TEST,
        S_SWAP_RD, S_SWAP_WA, S_SWAP_WB, S_PIV_RD, S_PIV_LD,
        S_DIV_RD, S_DIV_GO, S_DIV_WAIT, S_UPD_RD, S_UPD_MUL, S_UPD_WR,
        S_OUT_RD, S_OUT_LD, S_OUT_WAIT, S_SING
    } t_state;

    typedef struct packed {
        logic             in_ready;
        logic             init_perm;
        logic             srch_rd;
        logic             srch_cmp;
        logic             perm_swap;
        logic             swap_rd;
        logic             swap_wa;
        logic             swap_wb;
        logic             piv_rd;
        logic             piv_ld;
        logic             div_rd;
        logic             div_start;
        logic             div_wr;
        logic             upd_rd;
        logic             upd_mul;
        logic             upd_wr;
        logic             out_rd;
        logic             out_ld;
        logic             sing_ld;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic below_eps;
        logic swap_needed;
        logic div_done;
        logic out_valid;
        logic out_taken;
        logic out_last;
    } t_sts;

    function automatic logic [SIZE_W-1:0] order_of(input logic [SIZE_W-1:0] ms);
        logic [SIZE_W-1:0] r;
        if (ms == '0) begin
            r = SIZE_W'(1);
        end else if (ms > SIZE_W'(MAX_ORDER)) begin
            r = SIZE_W'(MAX_ORDER);
        end else begin
            r = ms;
        end
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_diff(
        input logic signed [DIFF_W-1:0] v
    );
        logic signed [DATA_WIDTH-1:0] r;
        if (v > DIFF_W'(SAT_MAX)) begin
            r = SAT_MAX;
        end else if (v < DIFF_W'(SAT_MIN)) begin
            r = SAT_MIN;
        end else begin
            r = v[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// File: design/lud_if.sv
// lud_if: request channels of the lu factorization block
// depends on lud_pkg

interface lud_in_if;
    import lud_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] matrix_element;
    logic                         last_element;

    modport source (output valid, matrix_element, last_element, input ready);
    modport sink   (input valid, matrix_element, last_element, output ready);
endinterface

interface lud_out_if;
    import lud_pkg::*;
    logic                         valid;
    logic                         ready;
    logic [IDX_W-1:0]             row_index;
    logic [IDX_W-1:0]             col_index;
    logic signed [DATA_WIDTH-1:0] lower_value;
    logic signed [DATA_WIDTH-1:0] upper_value;
    logic                         perm_bit;
    logic                         singular;
    logic                         last_result;

    modport source (output valid, row_index, col_index, lower_value, upper_value,
                    perm_bit, singular, last_result, input ready);
    modport sink   (input valid, row_index, col_index, lower_value, upper_value,
                    perm_bit, singular, last_result, output ready);
endinterface

// File: design/lud_div.sv
// lud_div: bit-serial signed q16.16 divider with saturation
// depends on lud_pkg

module lud_div
    import lud_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_num,
    input  logic signed [DATA_WIDTH-1:0] i_den,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_quot
);

    localparam int NUM_W  = DATA_WIDTH + FRAC_BITS;
    localparam int STEP_W = $clog2(NUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NUM_W-1:0]  r_acc;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_den;
    logic              r_neg;
    logic signed [DATA_WIDTH-1:0] r_quot;

    logic [DATA_WIDTH-1:0] num_mag;
    logic [DATA_WIDTH-1:0] den_mag;
    logic [DATA_WIDTH:0]   rem_sh;
    logic                  ge;
    logic [DATA_WIDTH-1:0] n_rem;
    logic [NUM_W-1:0]      n_acc;
    logic signed [DATA_WIDTH-1:0] n_quot;

    assign num_mag = i_num[DATA_WIDTH-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[DATA_WIDTH-1] ? (~i_den + 1'b1) : i_den;
    assign rem_sh  = {r_rem, r_acc[NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign n_rem   = ge ? DATA_WIDTH'(rem_sh - {1'b0, r_den}) : rem_sh[DATA_WIDTH-1:0];
    assign n_acc   = {r_acc[NUM_W-2:0], ge};

    always_comb begin
        if (r_neg) begin
            if (n_acc > NUM_W'({1'b1, {(DATA_WIDTH-1){1'b0}}})) begin
                n_quot = SAT_MIN;
            end else begin
                n_quot = ~n_acc[DATA_WIDTH-1:0] + 1'b1;
            end
        end else begin
            if (n_acc > NUM_W'(SAT_MAX)) begin
                n_quot = SAT_MAX;
            end else begin
                n_quot = n_acc[DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_step <= '0;
                if (i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= {num_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_den <= den_mag;
            r_neg <= i_num[DATA_WIDTH-1] ^ i_den[DATA_WIDTH-1];
            if (i_num == '0) begin
                r_quot <= '0;
            end else if (i_num[DATA_WIDTH-1]) begin
                r_quot <= SAT_MIN;
            end else begin
                r_quot <= SAT_MAX;
            end
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_rem <= n_rem;
            if (r_step == STEP_W'(NUM_W - 1)) begin
                r_quot <= n_quot;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: design/lud_dp.sv
// lud_dp: matrix memories, pivot search, divider, multiply-subtract and result register
// depends on lud_pkg, lud_if and lud_div

module lud_dp
    import lud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_sz,
    input  logic [EPS_W-1:0]  i_eps,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    lud_in_if.sink            i_in_req,
    lud_out_if.source         o_out_req
);

    logic signed [DATA_WIDTH-1:0] r_work [MAX_ORDER*MAX_ORDER];
    logic signed [DATA_WIDTH-1:0] r_lower [MAX_ORDER*MAX_ORDER];
    logic signed [DATA_WIDTH-1:0] r_work_a;
    logic signed [DATA_WIDTH-1:0] r_work_b;
    logic signed [DATA_WIDTH-1:0] r_low_a;
    logic signed [DATA_WIDTH-1:0] r_low_b;

    logic [CNT_W-1:0]      r_load_cnt;
    logic [IDX_W-1:0]      r_perm [MAX_ORDER];
    logic [IDX_W-1:0]      r_best;
    logic [DATA_WIDTH-1:0] r_bmag;
    logic signed [DATA_WIDTH-1:0] r_piv;
    logic signed [DATA_WIDTH-1:0] r_mult;
    logic signed [PROD_W-1:0]     r_prod;

    logic                         r_o_valid;
    logic [IDX_W-1:0]             r_o_row;
    logic [IDX_W-1:0]             r_o_col;
    logic signed [DATA_WIDTH-1:0] r_o_lower;
    logic signed [DATA_WIDTH-1:0] r_o_upper;
    logic                         r_o_perm;
    logic                         r_o_sing;
    logic                         r_o_last;

    logic              in_acc;
    logic [CNT_W-1:0]  total;
    logic [IDX_W-1:0]  ld_row;
    logic [CNT_W-1:0]  ld_col_full;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              rd_en;
    logic [ADDR_W-1:0] work_waddr;
    logic signed [DATA_WIDTH-1:0] work_wdata;
    logic              work_we;
    logic [ADDR_W-1:0] low_waddr;
    logic signed [DATA_WIDTH-1:0] low_wdata;
    logic              low_we;
    logic [DATA_WIDTH-1:0] cand_mag;
    logic signed [DIFF_W-1:0] diff;
    logic              div_done;
    logic signed [DATA_WIDTH-1:0] div_quot;
    logic              out_taken;
    logic [IDX_W-1:0]  last_idx;

    assign in_acc   = i_in_req.valid && i_cmd.in_ready;
    assign total    = CNT_W'({3'b0, i_sz} * {3'b0, i_sz});
    assign last_idx = IDX_W'(i_sz - 1'b1);

    always_comb begin
        ld_row = '0;
        for (int k = 1; k < MAX_ORDER; k++) begin
            if (CNT_W'(CNT_W'(k) * CNT_W'(i_sz)) <= r_load_cnt) begin
                ld_row = IDX_W'(k);
            end
        end
    end
    assign ld_col_full = r_load_cnt - CNT_W'(CNT_W'(ld_row) * CNT_W'(i_sz));

    always_comb begin
        rd_en     = i_cmd.srch_rd | i_cmd.swap_rd | i_cmd.piv_rd | i_cmd.div_rd
                  | i_cmd.upd_rd | i_cmd.out_rd;
        rd_addr_a = {i_cmd.i, i_cmd.n};
        rd_addr_b = {i_cmd.i, i_cmd.j};
        priority if (i_cmd.swap_rd) begin
            rd_addr_a = {i_cmd.n, i_cmd.j};
            rd_addr_b = {r_best, i_cmd.j};
        end else if (i_cmd.piv_rd) begin
            rd_addr_a = {i_cmd.n, i_cmd.n};
        end else if (i_cmd.upd_rd) begin
            rd_addr_a = {i_cmd.n, i_cmd.j};
        end else if (i_cmd.out_rd) begin
            rd_addr_a = {i_cmd.i, i_cmd.j};
        end
    end

    assign diff = DIFF_W'(r_work_b) - DIFF_W'($signed(r_prod[PROD_W-1:FRAC_BITS]));

    always_comb begin
        work_we    = 1'b0;
        work_waddr = {i_cmd.i, i_cmd.j};
        work_wdata = sat_diff(diff);
        low_we     = 1'b0;
        low_waddr  = {i_cmd.i, i_cmd.n};
        low_wdata  = div_quot;
        priority if (in_acc && r_load_cnt < total) begin
            work_we    = 1'b1;
            work_waddr = {ld_row, ld_col_full[IDX_W-1:0]};
            work_wdata = i_in_req.matrix_element;
        end else if (i_cmd.swap_wa) begin
            work_we    = 1'b1;
            work_waddr = {i_cmd.n, i_cmd.j};
            work_wdata = r_work_b;
            low_we     = 1'b1;
            low_waddr  = {i_cmd.n, i_cmd.j};
            low_wdata  = r_low_b;
        end else if (i_cmd.swap_wb) begin
            work_we    = 1'b1;
            work_waddr = {r_best, i_cmd.j};
            work_wdata = r_work_a;
            low_we     = 1'b1;
            low_waddr  = {r_best, i_cmd.j};
            low_wdata  = r_low_a;
        end else if (i_cmd.upd_wr) begin
            work_we = 1'b1;
        end else if (i_cmd.div_wr) begin
            // eliminated entry below the pivot becomes zero
            work_we    = 1'b1;
            work_waddr = {i_cmd.i, i_cmd.n};
            work_wdata = '0;
            low_we     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            r_work[work_waddr] <= work_wdata;
        end
        if (low_we) begin
            r_lower[low_waddr] <= low_wdata;
        end
        if (rd_en) begin
            r_work_a <= r_work[rd_addr_a];
            r_work_b <= r_work[rd_addr_b];
            r_low_a  <= r_lower[rd_addr_a];
            r_low_b  <= r_lower[rd_addr_b];
        end
    end

    assign cand_mag = r_work_a[DATA_WIDTH-1] ? (~r_work_a + 1'b1) : r_work_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_cmp) begin
            if (i_cmd.i == i_cmd.n || cand_mag > r_bmag) begin
                r_bmag <= cand_mag;
                r_best <= i_cmd.i;
            end
        end
        if (i_cmd.piv_ld) begin
            r_piv <= r_work_a;
        end
        if (i_cmd.div_wr) begin
            r_mult <= div_quot;
        end
        if (i_cmd.upd_mul) begin
            r_prod <= r_mult * r_work_a;
        end
    end

    lud_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_work_a),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_cnt <= '0;
            for (int k = 0; k < MAX_ORDER; k++) begin
                r_perm[k] <= IDX_W'(k);
            end
        end else begin
            if (in_acc) begin
                if (i_in_req.last_element) begin
                    r_load_cnt <= '0;
                end else if (r_load_cnt < total) begin
                    r_load_cnt <= r_load_cnt + 1'b1;
                end
            end
            if (i_cmd.init_perm) begin
                for (int k = 0; k < MAX_ORDER; k++) begin
                    r_perm[k] <= IDX_W'(k);
                end
            end else if (i_cmd.perm_swap) begin
                r_perm[i_cmd.n] <= r_perm[r_best];
                r_perm[r_best]  <= r_perm[i_cmd.n];
            end
        end
    end

    assign out_taken = r_o_valid && o_out_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_ld || i_cmd.sing_ld) begin
            r_o_valid <= 1'b1;
        end else if (out_taken) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_o_row   <= i_cmd.i;
            r_o_col   <= i_cmd.j;
            r_o_lower <= (i_cmd.i > i_cmd.j) ? r_low_a
                       : ((i_cmd.i == i_cmd.j) ? Q_ONE : '0);
            r_o_upper <= (i_cmd.i <= i_cmd.j) ? r_work_a : '0;
            r_o_perm  <= r_perm[i_cmd.j] == i_cmd.i;
            r_o_sing  <= 1'b0;
            r_o_last  <= (i_cmd.i == last_idx) && (i_cmd.j == last_idx);
        end else if (i_cmd.sing_ld) begin
            r_o_row   <= '0;
            r_o_col   <= '0;
            r_o_lower <= '0;
            r_o_upper <= '0;
            r_o_perm  <= 1'b0;
            r_o_sing  <= 1'b1;
            r_o_last  <= 1'b1;
        end
    end

    assign i_in_req.ready        = i_cmd.in_ready;
    assign o_out_req.valid       = r_o_valid;
    assign o_out_req.row_index   = r_o_row;
    assign o_out_req.col_index   = r_o_col;
    assign o_out_req.lower_value = r_o_lower;
    assign o_out_req.upper_value = r_o_upper;
    assign o_out_req.perm_bit    = r_o_perm;
    assign o_out_req.singular    = r_o_sing;
    assign o_out_req.last_result = r_o_last;

    assign o_sts.in_last     = in_acc && i_in_req.last_element;
    assign o_sts.below_eps   = r_bmag < DATA_WIDTH'(i_eps);
    assign o_sts.swap_needed = r_best != i_cmd.n;
    assign o_sts.div_done    = div_done;
    assign o_sts.out_valid   = r_o_valid;
    assign o_sts.out_taken   = out_taken;
    assign o_sts.out_last    = r_o_last;

endmodule

// File: design/lud_ctrl.sv
// lud_ctrl: sequencer for load, pivot search, row swap, elimination and result streaming
// depends on lud_pkg

module lud_ctrl
    import lud_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SIZE_W-1:0] i_sz,
    input  t_sts              i_sts,
    output t_cmd              o_cmd
);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;

    logic n_more;
    logic i_more;
    logic j_more;
    logic j_all_more;

    assign n_more     = (SIZE_W'(r_n) + 1'b1) < i_sz;
    assign i_more     = (SIZE_W'(r_i) + 1'b1) < i_sz;
    assign j_more     = (SIZE_W'(r_j) + 1'b1) < i_sz;
    // row swaps cover every stored column
    assign j_all_more = r_j != IDX_W'(MAX_ORDER - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:     if (i_sts.in_last) n_state = S_INIT;
            S_INIT:     n_state = S_COL;
            S_COL:      n_state = n_more ? S_SRCH_RD : S_OUT_RD;
            S_SRCH_RD:  n_state = S_SRCH_CMP;
            S_SRCH_CMP: n_state = i_more ? S_SRCH_RD : S_TEST;
            S_TEST: begin
                priority if (i_sts.below_eps) n_state = S_SING;
                else if (i_sts.swap_needed)   n_state = S_SWAP_RD;
                else                          n_state = S_PIV_RD;
            end
            S_SWAP_RD:  n_state = S_SWAP_WA;
            S_SWAP_WA:  n_state = S_SWAP_WB;
            S_SWAP_WB:  n_state = j_all_more ? S_SWAP_RD : S_PIV_RD;
            S_PIV_RD:   n_state = S_PIV_LD;
            S_PIV_LD:   n_state = S_DIV_RD;
            S_DIV_RD:   n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: if (i_sts.div_done) n_state = S_UPD_RD;
            S_UPD_RD:   n_state = S_UPD_MUL;
            S_UPD_MUL:  n_state = S_UPD_WR;
            S_UPD_WR: begin
                priority if (j_more) n_state = S_UPD_RD;
                else if (i_more)     n_state = S_DIV_RD;
                else                 n_state = S_COL;
            end
            S_OUT_RD:   n_state = S_OUT_LD;
            S_OUT_LD:   n_state = S_OUT_WAIT;
            S_OUT_WAIT: begin
                if (i_sts.out_taken) n_state = i_sts.out_last ? S_LOAD : S_OUT_RD;
            end
            S_SING:     n_state = S_OUT_WAIT;
            default:    n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_n = r_n;
        n_i = r_i;
        n_j = r_j;
        unique case (r_state)
            S_INIT: n_n = '0;
            S_COL: begin
                n_i = n_more ? r_n : '0;
                n_j = '0;
            end
            S_SRCH_CMP: if (i_more) n_i = r_i + 1'b1;
            S_TEST:     n_j = '0;
            S_SWAP_WB:  if (j_all_more) n_j = r_j + 1'b1;
            S_PIV_LD:   n_i = r_n + 1'b1;
            S_DIV_WAIT: n_j = r_n + 1'b1;
            S_UPD_WR: begin
                priority if (j_more) begin
                    n_j = r_j + 1'b1;
                end else if (i_more) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_n = r_n + 1'b1;
                end
            end
            S_OUT_WAIT: begin
                if (i_sts.out_taken && !i_sts.out_last) begin
                    if (j_more) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_j = '0;
                        n_i = r_i + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.n         = r_n;
        o_cmd.i         = r_i;
        o_cmd.j         = r_j;
        o_cmd.in_ready  = r_state == S_LOAD;
        o_cmd.init_perm = r_state == S_INIT;
        o_cmd.srch_rd   = r_state == S_SRCH_RD;
        o_cmd.srch_cmp  = r_state == S_SRCH_CMP;
        o_cmd.perm_swap = (r_state == S_TEST) && !i_sts.below_eps && i_sts.swap_needed;
        o_cmd.swap_rd   = r_state == S_SWAP_RD;
        o_cmd.swap_wa   = r_state == S_SWAP_WA;
        o_cmd.swap_wb   = r_state == S_SWAP_WB;
        o_cmd.piv_rd    = r_state == S_PIV_RD;
        o_cmd.piv_ld    = r_state == S_PIV_LD;
        o_cmd.div_rd    = r_state == S_DIV_RD;
        o_cmd.div_start = r_state == S_DIV_GO;
        o_cmd.div_wr    = (r_state == S_DIV_WAIT) && i_sts.div_done;
        o_cmd.upd_rd    = r_state == S_UPD_RD;
        o_cmd.upd_mul   = r_state == S_UPD_MUL;
        o_cmd.upd_wr    = r_state == S_UPD_WR;
        o_cmd.out_rd    = r_state == S_OUT_RD;
        o_cmd.out_ld    = r_state == S_OUT_LD;
        o_cmd.sing_ld   = r_state == S_SING;
    end

    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.in_ready |-> !i_sts.out_valid)
        else $error("input taken while a result is pending");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> (r_state == S_DIV_WAIT))
        else $error("divider started outside the elimination sequence");

    a_upd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.upd_wr |-> (r_i > r_n && r_j > r_n && SIZE_W'(r_i) < i_sz
                          && SIZE_W'(r_j) < i_sz))
        else $error("elimination index out of range");

endmodule

// File: design/lu_decompose_partial_pivot_top.sv
// LU factorization with partial pivoting, Q16.16. A matrix of order 1 to 8 loads
// row-major at one element per cycle; the element flagged last starts the run. The
// run then does, per column n, a pivot search over the candidate rows, a row swap
// across all eight stored columns when needed, a bit-serial divide for each row below
// the pivot and an update of each element through the single multiplier and
// one-write-port memory; each result is read out only after the previous one has
// been taken. The full order-8 run is dominated by the divider.
// depends on lud_pkg, lud_if, lud_ctrl, lud_dp

module lu_decompose_partial_pivot_top
    import lud_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [0:0]       i_cfg_index,
    input  logic [EPS_W-1:0] i_cfg_wdata,
    lud_in_if.sink           i_in_req,
    lud_out_if.source        o_out_req
);

    logic [SIZE_W-1:0] r_matrix_size;
    logic [EPS_W-1:0]  r_pivot_eps;
    logic [SIZE_W-1:0] sz;
    t_cmd              cmd;
    t_sts              sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= SIZE_W'(MAX_ORDER);
            r_pivot_eps   <= EPS_W'(1);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_MATRIX_SIZE:   r_matrix_size <= i_cfg_wdata[SIZE_W-1:0];
                CFG_PIVOT_EPSILON: r_pivot_eps   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign sz = order_of(r_matrix_size);

    lud_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sz    (sz),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    lud_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sz      (sz),
        .i_eps     (r_pivot_eps),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_in_req  (i_in_req),
        .o_out_req (o_out_req)
    );

endmodule
